@@ rtl/core/gfla_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfla_pkg
// Shared types, constants and helpers for the GF(2^8) log/exp ALU.
// ----------------------------------------------------------------------------
package gfla_pkg;

    // Operation codes
    localparam logic [2:0] FUNC_ADD = 3'd0;
    localparam logic [2:0] FUNC_MUL = 3'd1;
    localparam logic [2:0] FUNC_DIV = 3'd2;
    localparam logic [2:0] FUNC_LOG = 3'd3;
    localparam logic [2:0] FUNC_EXP = 3'd4;

    // Field constants
    localparam logic [8:0] GF_POLY  = 9'h11B;
    localparam logic [7:0] GF_ORDER = 8'd255;
    localparam int         EXP_DEPTH = 255;
    localparam int         LOG_DEPTH = 256;

    // One table write from the build sweep: exp[idx] = elem, log[elem] = idx
    typedef struct packed {
        logic       we;
        logic [7:0] idx;
        logic [7:0] elem;
    } tbl_wr_t;

    // Multiply a field element by the generator 3
    function automatic logic [7:0] gf_mul3(input logic [7:0] p);
        logic [8:0] x;
        begin
            x = {p, 1'b0} ^ {1'b0, p};
            if (x[8])
            begin
                x = x ^ GF_POLY;
            end
            return x[7:0];
        end
    endfunction

endpackage

@@ rtl/core/gfla_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfla_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module gfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr0,
    input  logic [AW-1:0]    raddr1,
    output logic [WIDTH-1:0] rdata0,
    output logic [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata0_reg;
    logic [WIDTH-1:0] rdata1_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports; hold data while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata0_reg <= mem[raddr0];
            rdata1_reg <= mem[raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

@@ rtl/core/gfla_sweep.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfla_sweep
// Build sweep: walks the powers of 3 once after reset, one per cycle,
// and emits the matching exp and log table writes.
// ----------------------------------------------------------------------------
module gfla_sweep
    import gfla_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    output tbl_wr_t wr,
    output logic    done
);

    logic [7:0] idx_reg;
    logic [7:0] idx_next;
    logic [7:0] pow_reg;
    logic [7:0] pow_next;
    logic       done_reg;
    logic       done_next;

    // Advance the power and index until the last power is written
    always_comb
    begin
        idx_next  = idx_reg;
        pow_next  = pow_reg;
        done_next = done_reg;
        if (!done_reg)
        begin
            idx_next = idx_reg + 8'd1;
            pow_next = gf_mul3(pow_reg);
            if (idx_reg == GF_ORDER - 8'd1)
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 8'd0;
            pow_reg  <= 8'd1;
            done_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            pow_reg  <= pow_next;
            done_reg <= done_next;
        end
    end

    assign wr.we   = !done_reg;
    assign wr.idx  = idx_reg;
    assign wr.elem = pow_reg;
    assign done    = done_reg;

    // Sweep never runs past the last exp entry
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        !done_reg |-> idx_reg != GF_ORDER)
        else $error("sweep index out of range");

endmodule

@@ rtl/core/gfla_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfla_pipe
// Three-stage datapath around the log and exp memories: log lookup,
// exponent index and exp lookup, result select into the output register.
// ----------------------------------------------------------------------------
module gfla_pipe
    import gfla_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  tbl_wr_t    wr,
    input  logic       tables_done,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] func,
    input  logic [7:0] operand_a,
    input  logic [7:0] operand_b,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] result
);

    // Stage enables
    logic out_load;
    logic s2_en;
    logic s1_en;

    // Stage 1: log lookup in flight
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [2:0] s1_func_reg;
    logic [7:0] s1_a_reg;
    logic [7:0] s1_b_reg;

    // Stage 2: exp lookup in flight
    logic       s2_valid_reg;
    logic       s2_valid_next;
    logic [2:0] s2_func_reg;
    logic [7:0] s2_a_reg;
    logic [7:0] s2_b_reg;
    logic [7:0] s2_la_reg;
    logic       s2_zero_reg;

    // Output register
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] result_reg;
    logic [7:0] result_next;

    // Memory ports
    logic [7:0] log_rd_a;
    logic [7:0] log_rd_b;
    logic [7:0] exp_rd;
    logic [7:0] exp_idx;

    // Stage 1 arithmetic
    logic [7:0] la;
    logic [7:0] lb;
    logic [8:0] sum9;
    logic [7:0] mul_idx;
    logic [7:0] div_idx;
    logic       opd_zero;

    // Pipeline flow: each stage loads when its successor can take its beat
    assign out_load = !out_valid_reg || out_ready;
    assign s2_en    = !s2_valid_reg || out_load;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = tables_done && s1_en;

    gfla_ram #(
        .WIDTH (8),
        .DEPTH (LOG_DEPTH)
    ) u_log_ram (
        .clk    (clk),
        .we     (wr.we),
        .waddr  (wr.elem),
        .wdata  (wr.idx),
        .re     (s1_en),
        .raddr0 (operand_a),
        .raddr1 (operand_b),
        .rdata0 (log_rd_a),
        .rdata1 (log_rd_b)
    );

    gfla_ram #(
        .WIDTH (8),
        .DEPTH (EXP_DEPTH)
    ) u_exp_ram (
        .clk    (clk),
        .we     (wr.we),
        .waddr  (wr.idx),
        .wdata  (wr.elem),
        .re     (s2_en),
        .raddr0 (exp_idx),
        .raddr1 (8'd0),
        .rdata0 (exp_rd),
        .rdata1 ()
    );

    // Log of zero reads as zero; entry zero is never written
    assign la = (s1_a_reg == 8'd0) ? 8'd0 : log_rd_a;
    assign lb = (s1_b_reg == 8'd0) ? 8'd0 : log_rd_b;

    // Sum and difference of logs, mod 255
    assign sum9    = {1'b0, la} + {1'b0, lb};
    assign mul_idx = (sum9 >= {1'b0, GF_ORDER}) ? 8'(sum9 - {1'b0, GF_ORDER}) : sum9[7:0];
    assign div_idx = (la >= lb) ? 8'(la - lb) : 8'(la + GF_ORDER - lb);

    // Pick the exp index for this operation
    always_comb
    begin
        case (s1_func_reg)
            FUNC_MUL: exp_idx = mul_idx;
            FUNC_DIV: exp_idx = div_idx;
            FUNC_EXP: exp_idx = (s1_a_reg == GF_ORDER) ? 8'd0 : s1_a_reg;
            default:  exp_idx = 8'd0;
        endcase
    end

    // Zero operand forces a zero product or quotient
    always_comb
    begin
        case (s1_func_reg)
            FUNC_MUL: opd_zero = (s1_a_reg == 8'd0) || (s1_b_reg == 8'd0);
            FUNC_DIV: opd_zero = (s1_a_reg == 8'd0);
            default:  opd_zero = 1'b0;
        endcase
    end

    // Select the result
    always_comb
    begin
        case (s2_func_reg)
            FUNC_ADD: result_next = s2_a_reg ^ s2_b_reg;
            FUNC_MUL,
            FUNC_DIV: result_next = s2_zero_reg ? 8'd0 : exp_rd;
            FUNC_LOG: result_next = s2_la_reg;
            FUNC_EXP: result_next = exp_rd;
            default:  result_next = 8'd0;
        endcase
    end

    assign s1_valid_next  = s1_en ? (in_valid && in_ready) : s1_valid_reg;
    assign s2_valid_next  = s2_en ? s1_valid_reg : s2_valid_reg;
    assign out_valid_next = out_load ? s2_valid_reg : out_valid_reg;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_func_reg <= func;
            s1_a_reg    <= operand_a;
            s1_b_reg    <= operand_b;
        end
        if (s2_en)
        begin
            s2_func_reg <= s1_func_reg;
            s2_a_reg    <= s1_a_reg;
            s2_b_reg    <= s1_b_reg;
            s2_la_reg   <= la;
            s2_zero_reg <= opd_zero;
        end
        if (out_load)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // No item enters before the tables are complete
    a_ready_tables: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> tables_done && !wr.we)
        else $error("item accepted during table build");

    // Exp index always inside the table
    a_exp_idx: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> exp_idx != GF_ORDER)
        else $error("exp index out of range");

    // A product with a zero factor comes out zero
    a_mul_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && out_load && s2_func_reg == FUNC_MUL && s2_zero_reg)
        |=> result_reg == 8'd0)
        else $error("zero factor gave nonzero product");

    // Output beat only appears from a valid stage 2
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_valid_reg))
        else $error("output valid without source");

endmodule

@@ rtl/core/gf256_log_exp_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf256_log_exp_alu
// GF(2^8) ALU (polynomial 0x11B, generator 3) built on log and exp memories.
//
// Usage:
//   Input channel in_valid/in_ready carries func, operand_a, operand_b.
//   Output channel out_valid/out_ready carries result, one beat per input.
//   func: add, multiply, divide, log of a, exp of a; other codes give 0.
//   After reset the exp and log memories are filled by a sweep over all
//   255 powers of 3; in_ready stays low until it finishes.
//   Each item is registered in stage 1, stage 2, then the output register.
//   Throughput: one beat per cycle unless stalled, from one log-memory read
//   (two ports) and one exp-memory read per item, each in its own stage.
//   When the receiver stalls, the output register holds its beat and the
//   two inner stages keep accepting until they are full, then in_ready
//   drops; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module gf256_log_exp_alu
    import gfla_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] func,
    input  logic [7:0] operand_a,
    input  logic [7:0] operand_b,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] result
);

    tbl_wr_t tbl_wr;
    logic    tables_done;

    // Table build sweep
    gfla_sweep u_sweep (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (tbl_wr),
        .done  (tables_done)
    );

    // Lookup pipeline
    gfla_pipe u_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (tbl_wr),
        .tables_done (tables_done),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .operand_a   (operand_a),
        .operand_b   (operand_b),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result      (result)
    );

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the GF(2^8) log/exp ALU (polynomial 0x11B, generator 3).
// A short directed table covers field extremes, every operation code and
// the zero and wrap corner cases. Random beats follow, most of them valid
// operations with operands biased toward 0, 1 and 0xFF. Each accepted input
// beat queues its expected byte: either typed into the table or computed by
// a local log/exp table model. Each output beat is matched against the
// oldest entry. Both channels idle at random, and one long receiver hold
// backs the pipeline up into the input.
// ----------------------------------------------------------------------------
module tb;
    import gfla_pkg::*;

    localparam logic [2:0] FUNC_RSVD5 = 3'd5;
    localparam logic [2:0] FUNC_RSVD6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;

    localparam int RANDOM_BEATS = 1600;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct {
        logic [2:0] fn;
        logic [7:0] a;
        logic [7:0] b;
        bit         typed;
        logic [7:0] want;
    } vec_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] func;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] result;

    // Side band that travels with each input beat to the checker
    bit         beat_typed;
    logic [7:0] beat_want;

    logic [7:0] exp_tab [0:254];
    logic [7:0] log_tab [0:255];
    logic [7:0] pending_bytes [$];
    int         error_count;
    int         beats_taken;
    int         cycle_count;
    int         calm_left;

    vec_t corner_vecs [0:23] = '{
        '{FUNC_ADD,   8'h00, 8'h00, 1'b1, 8'h00},
        '{FUNC_ADD,   8'hFF, 8'hFF, 1'b1, 8'h00},
        '{FUNC_ADD,   8'hFF, 8'h00, 1'b1, 8'hFF},
        '{FUNC_ADD,   8'hA5, 8'h5A, 1'b1, 8'hFF},
        '{FUNC_MUL,   8'h00, 8'hFF, 1'b1, 8'h00},
        '{FUNC_MUL,   8'hFF, 8'h00, 1'b1, 8'h00},
        '{FUNC_MUL,   8'hFF, 8'hFF, 1'b0, 8'h00},
        '{FUNC_MUL,   8'h01, 8'hB7, 1'b1, 8'hB7},
        '{FUNC_DIV,   8'h00, 8'hFF, 1'b1, 8'h00},
        '{FUNC_DIV,   8'h00, 8'h00, 1'b1, 8'h00},
        '{FUNC_DIV,   8'hC3, 8'h00, 1'b1, 8'hC3},
        '{FUNC_DIV,   8'hFF, 8'hFF, 1'b1, 8'h01},
        '{FUNC_DIV,   8'h01, 8'hFF, 1'b0, 8'h00},
        '{FUNC_LOG,   8'h00, 8'hFF, 1'b1, 8'h00},
        '{FUNC_LOG,   8'h01, 8'h00, 1'b1, 8'h00},
        '{FUNC_LOG,   8'h03, 8'h00, 1'b1, 8'h01},
        '{FUNC_LOG,   8'hFF, 8'hFF, 1'b0, 8'h00},
        '{FUNC_EXP,   8'h00, 8'h00, 1'b1, 8'h01},
        '{FUNC_EXP,   8'h01, 8'h00, 1'b1, 8'h03},
        '{FUNC_EXP,   8'hFF, 8'h00, 1'b1, 8'h01},
        '{FUNC_EXP,   8'hFE, 8'hFF, 1'b0, 8'h00},
        '{FUNC_RSVD5, 8'hFF, 8'hFF, 1'b1, 8'h00},
        '{FUNC_RSVD6, 8'h00, 8'h00, 1'b1, 8'h00},
        '{FUNC_RSVD7, 8'hFF, 8'hFF, 1'b1, 8'h00}
    };

    gf256_log_exp_alu u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Compute one field result from the local log/exp tables
    function automatic logic [7:0] gf_result(input logic [2:0] fn, input logic [7:0] a,
                                             input logic [7:0] b);
        int la;
        int lb;
        logic [7:0] r;
        begin
            la = log_tab[a];
            lb = log_tab[b];
            r  = 8'h00;
            case (fn)
                FUNC_ADD: r = a ^ b;
                FUNC_MUL:
                begin
                    if (a != 8'h00 && b != 8'h00)
                    begin
                        r = exp_tab[(la + lb) % 255];
                    end
                end
                FUNC_DIV:
                begin
                    if (a != 8'h00)
                    begin
                        r = exp_tab[(255 + la - lb) % 255];
                    end
                end
                FUNC_LOG: r = log_tab[a];
                FUNC_EXP: r = exp_tab[int'(a) % 255];
                default:  r = 8'h00;
            endcase
            return r;
        end
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        begin
            r = $urandom_range(99, 0);
            if (r < 55)
            begin
                return 0;
            end
            else if (r < 90)
            begin
                return $urandom_range(3, 1);
            end
            return $urandom_range(30, 8);
        end
    endfunction

    // Operand byte biased toward the corner values
    function automatic logic [7:0] pick_byte();
        int r;
        begin
            r = $urandom_range(99, 0);
            if (r < 10)
            begin
                return 8'h00;
            end
            else if (r < 15)
            begin
                return 8'hFF;
            end
            else if (r < 20)
            begin
                return 8'h01;
            end
            return 8'($urandom_range(255, 0));
        end
    endfunction

    // Print one mismatch line and count it
    task automatic flag_mismatch(input string msg);
        begin
            $display("tb: mismatch at %0t: %s", $realtime, msg);
            error_count++;
        end
    endtask

    // Offer one beat after a random gap and hold it until taken
    task automatic send_beat(input logic [2:0] fn, input logic [7:0] a, input logic [7:0] b,
                             input bit typed, input logic [7:0] want);
        int gap;
        begin
            if (calm_left > 0)
            begin
                gap = 0;
                calm_left--;
            end
            else
            begin
                gap = idle_len();
                if ($urandom_range(24, 0) == 0)
                begin
                    calm_left = $urandom_range(60, 20);
                end
            end
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid   <= 1'b1;
            func       <= fn;
            operand_a  <= a;
            operand_b  <= b;
            beat_typed <= typed;
            beat_want  <= want;
            do
            begin
                @(posedge clk);
            end
            while (!in_ready);
            @(negedge clk);
        end
    endtask

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Queue expected bytes on input beats, match them on output beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                pending_bytes.push_back(beat_typed ? beat_want
                                                   : gf_result(func, operand_a, operand_b));
                beats_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (pending_bytes.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected result %02h", result));
                end
                else if (result !== pending_bytes[0])
                begin
                    flag_mismatch($sformatf("result %02h, want %02h", result,
                                            pending_bytes[0]));
                    void'(pending_bytes.pop_front());
                end
                else
                begin
                    void'(pending_bytes.pop_front());
                end
            end
        end
    end

    // Receiver: random ready, with one long hold once traffic is under way
    initial
    begin : receiver
        int run;
        bit held;
        held = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held && beats_taken >= 400)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            run = ($urandom_range(9, 0) == 0) ? $urandom_range(100, 30) : $urandom_range(8, 1);
            out_ready <= 1'b1;
            repeat (run) @(negedge clk);
            run = idle_len();
            if (run > 0)
            begin
                out_ready <= 1'b0;
                repeat (run) @(negedge clk);
            end
        end
    end

    // Sender and run control
    initial
    begin : main
        logic [8:0] p;
        logic [2:0] fn;
        int         guard;
        error_count = 0;
        beats_taken = 0;
        cycle_count = 0;
        calm_left   = 0;

        // Build the log/exp tables by powers of the generator
        p = 9'd1;
        log_tab[0] = 8'h00;
        for (int i = 0; i < 255; i++)
        begin
            exp_tab[i]    = p[7:0];
            log_tab[p[7:0]] = 8'(i);
            p = {p[7:0], 1'b0} ^ {1'b0, p[7:0]};
            if (p[8])
            begin
                p = p ^ 9'h11B;
            end
        end

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        func       <= FUNC_ADD;
        operand_a  <= 8'h00;
        operand_b  <= 8'h00;
        beat_typed <= 1'b0;
        beat_want  <= 8'h00;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed corners
        foreach (corner_vecs[i])
        begin
            send_beat(corner_vecs[i].fn, corner_vecs[i].a, corner_vecs[i].b,
                      corner_vecs[i].typed, corner_vecs[i].want);
        end

        // Random traffic, reserved codes now and then
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if ($urandom_range(99, 0) < 92)
            begin
                fn = 3'($urandom_range(4, 0));
            end
            else
            begin
                fn = 3'($urandom_range(7, 5));
            end
            send_beat(fn, pick_byte(), pick_byte(), 1'b0, 8'h00);
        end
        in_valid <= 1'b0;

        // Drain, then allow the pipeline to settle
        guard = 0;
        while (pending_bytes.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_bytes.size() != 0)
        begin
            flag_mismatch($sformatf("%0d results never arrived", pending_bytes.size()));
        end

        if (error_count == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

@@ gf256_log_exp_alu.f @@
rtl/core/gfla_pkg.sv
rtl/core/gfla_ram.sv
rtl/core/gfla_sweep.sv
rtl/core/gfla_pipe.sv
rtl/core/gf256_log_exp_alu.sv
bench/tb.sv
